// ----- design/esort_pkg.sv -----
// ----------------------------------------------------------------------------
// esort_pkg: shared types for the exchange selection sorter
// Sequencer states and the per-result flag bundle.
// ----------------------------------------------------------------------------
package esort_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,   // collecting elements
    S_RDI,    // read anchor entry i
    S_GETI,   // latch anchor, read first candidate
    S_CMP,    // compare/exchange one candidate per cycle
    S_WRI,    // write the anchor back to entry i
    S_EMIT    // stream sorted entries out
  } state_t;

  // Flags that travel with each result
  typedef struct packed {
    logic valid;
    logic last;
    logic overflow;
  } out_flags_t;

endpackage

// ----- design/esort_ram.sv -----
// ----------------------------------------------------------------------------
// esort_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module esort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/esort_seq.sv -----
// ----------------------------------------------------------------------------
// esort_seq: load / sort / emit sequencer
// Drives the element RAM: fills it in arrival order, runs the exchange
// selection sort with the anchor value held in a register, then reads out.
// ----------------------------------------------------------------------------
module esort_seq #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               in_value,
  input  logic                      in_last_in,
  output logic                      busy,
  output logic                      ram_we,
  output logic [$clog2(DEPTH)-1:0]  ram_waddr,
  output logic [31:0]               ram_wdata,
  output logic                      ram_re,
  output logic [$clog2(DEPTH)-1:0]  ram_raddr,
  input  logic [31:0]               ram_rdata,
  output esort_pkg::out_flags_t     flags
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);
  localparam logic [CW-1:0] TwoC   = CW'(2);

  esort_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  drop_r, drop_nxt;
  logic [AW-1:0]         i_r, i_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic [31:0]           a_r, a_nxt;
  esort_pkg::out_flags_t flags_r, flags_nxt;

  logic accept;
  logic room;
  logic gt;
  logic j_done;
  logic i_more;
  logic k_last;

  assign busy   = (state_r != esort_pkg::S_LOAD);
  assign accept = start && !busy;
  assign room   = (count_r < DepthC);
  // anchor strictly greater than candidate -> exchange
  assign gt     = $signed(a_r) > $signed(ram_rdata);
  assign j_done = (({1'b0, j_r} + OneC) >= count_r);
  assign i_more = (({1'b0, i_r} + TwoC) < count_r);
  assign k_last = (({1'b0, j_r} + OneC) == count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      esort_pkg::S_LOAD: begin
        if (accept && in_last_in) begin
          state_nxt = (count_r == '0) ? esort_pkg::S_EMIT : esort_pkg::S_RDI;
        end
      end
      esort_pkg::S_RDI:  state_nxt = esort_pkg::S_GETI;
      esort_pkg::S_GETI: state_nxt = esort_pkg::S_CMP;
      esort_pkg::S_CMP: begin
        if (j_done) begin
          state_nxt = esort_pkg::S_WRI;
        end
      end
      esort_pkg::S_WRI: begin
        state_nxt = i_more ? esort_pkg::S_RDI : esort_pkg::S_EMIT;
      end
      esort_pkg::S_EMIT: begin
        if (k_last) begin
          state_nxt = esort_pkg::S_LOAD;
        end
      end
      default: state_nxt = esort_pkg::S_LOAD;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    flags_nxt = '0;
    ram_we    = 1'b0;
    ram_waddr = i_r;
    ram_wdata = a_r;
    ram_re    = 1'b0;
    ram_raddr = i_r;
    case (state_r)
      esort_pkg::S_LOAD: begin
        if (accept) begin
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[AW-1:0];
            ram_wdata = in_value;
            count_nxt = count_r + OneC;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_in) begin
            i_nxt = '0;
            j_nxt = '0;
          end
        end
      end
      esort_pkg::S_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = i_r;
      end
      esort_pkg::S_GETI: begin
        a_nxt     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = i_r + 1'b1;
        j_nxt     = i_r + 1'b1;
      end
      esort_pkg::S_CMP: begin
        // exchange: candidate slot takes the anchor, anchor takes candidate
        if (gt) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = a_r;
          a_nxt     = ram_rdata;
        end
        if (!j_done) begin
          ram_re    = 1'b1;
          ram_raddr = j_r + 1'b1;
          j_nxt     = j_r + 1'b1;
        end
      end
      esort_pkg::S_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = a_r;
        i_nxt     = i_r + 1'b1;
        j_nxt     = '0;
      end
      esort_pkg::S_EMIT: begin
        // j_r is the readout index here
        ram_re             = 1'b1;
        ram_raddr          = j_r;
        j_nxt              = j_r + 1'b1;
        flags_nxt.valid    = 1'b1;
        flags_nxt.last     = k_last;
        flags_nxt.overflow = drop_r;
        if (k_last) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esort_pkg::S_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
      flags_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Indexes and anchor value
  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    a_r <= a_nxt;
  end

  assign flags = flags_r;

endmodule

// ----- design/exchange_selection_sorter.sv -----
// ----------------------------------------------------------------------------
// exchange_selection_sorter: batch sorter for signed 32-bit values
// Collects a batch, sorts it ascending in RAM, streams the result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present in_value / in_last_in with start; a transfer happens on a
//   clock edge with start high and busy low. Loading takes one element per
//   cycle. Elements past DEPTH are dropped and flag out_overflow on the batch.
//   in_last_in closes the batch and starts the sort; busy stays high until
//   the final result has been issued.
//   Sort: one compare per cycle through the single RAM read port, then the
//   sorted batch is read out of the RAM in order.
//   Each result shows in the cycle after its readout cycle, so the first
//   one follows the first readout after the sort, then one result per cycle;
//   out_last_out marks the final one. A batch of one element skips the sort.
//   Output: each result is shown for exactly one cycle with out_valid; the
//   receiver cannot stall. busy drops while the final result is shown.
//   Reset (rst_n low, synchronous) empties the batch and returns to loading;
//   RAM contents are not cleared.
// ----------------------------------------------------------------------------
module exchange_selection_sorter #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic        in_last_in,
  output logic        out_valid,
  output logic [31:0] out_sorted_value,
  output logic        out_last_out,
  output logic        out_overflow
);

  localparam int AW = $clog2(DEPTH);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [31:0]           ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [31:0]           ram_rdata;
  esort_pkg::out_flags_t flags;

  // Sequencer
  esort_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_value   (in_value),
    .in_last_in (in_last_in),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .flags      (flags)
  );

  // Element store
  esort_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result ports: RAM read register carries the value
  assign out_valid        = flags.valid;
  assign out_last_out     = flags.last;
  assign out_overflow     = flags.overflow;
  assign out_sorted_value = ram_rdata;

`ifndef SYNTHESIS
  // Leaving the busy phase coincides with the final result of the batch
  a_end_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_valid && out_last_out))
    else $error("busy dropped without final result");

  // No result right after the final one of a batch
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid)
    else $error("result issued directly after batch end");

  // Results only during the readout phase
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || out_last_out))
    else $error("result outside readout");
`endif

endmodule
